/* sv/matrix4_inverse_assert.svh */
// Assertion macros for the 4x4 matrix inverse block.
`ifndef MATRIX4_INVERSE_ASSERT_SVH
`define MATRIX4_INVERSE_ASSERT_SVH

`ifndef SYNTH

// Property must hold at every rising clock edge outside reset.
`define M4I_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define M4I_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define M4I_ASSERT(lbl, clk, rst_n, prop, msg)
`define M4I_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

/* sv/m4i_pkg.sv */
package m4i_pkg;

	localparam int FRAC_BITS_DEF  = 16;
	localparam int ELEM_WIDTH_DEF = 32;
	localparam int PORT_W         = 32;

	// sequencer states
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_FETCH1,
		ST_FETCH2,
		ST_MAC_GO,
		ST_MAC_WAIT,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_EMIT
	} state_t;

	// which quantity is being accumulated
	typedef enum logic [1:0] {
		PH_MINOR,
		PH_DET,
		PH_COF
	} phase_t;

	// command to the shared serial unit
	typedef struct packed {
		logic start;
		logic div;
		logic clr;
		logic sub;
	} unit_cmd_t;

	// first and second row of each 2x2 minor
	function automatic logic [1:0] pair_a(input logic [2:0] p);
		logic [1:0] r;
		unique case (p)
			3'd0, 3'd1, 3'd2: r = 2'd0;
			3'd3, 3'd4:       r = 2'd1;
			default:          r = 2'd2;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] pair_b(input logic [2:0] p);
		logic [1:0] r;
		unique case (p)
			3'd0:       r = 2'd1;
			3'd1, 3'd3: r = 2'd2;
			default:    r = 2'd3;
		endcase
		return r;
	endfunction

	// element row used by each cofactor term of an output column
	function automatic logic [1:0] cof_row(input logic [1:0] c, input logic [2:0] s);
		logic [1:0] r;
		unique case (s)
			3'd0:    r = (c == 2'd0) ? 2'd1 : 2'd0;
			3'd1:    r = (c <= 2'd1) ? 2'd2 : 2'd1;
			default: r = (c == 2'd3) ? 2'd2 : 2'd3;
		endcase
		return r;
	endfunction

	// minor used by each cofactor term of an output column
	function automatic logic [2:0] cof_minor(input logic [1:0] c, input logic [2:0] s);
		logic [2:0] r;
		unique case ({c, s[1:0]})
			4'b00_00: r = 3'd5;
			4'b00_01: r = 3'd4;
			4'b00_10: r = 3'd3;
			4'b01_00: r = 3'd5;
			4'b01_01: r = 3'd2;
			4'b01_10: r = 3'd1;
			4'b10_00: r = 3'd4;
			4'b10_01: r = 3'd2;
			4'b10_10: r = 3'd0;
			4'b11_00: r = 3'd3;
			4'b11_01: r = 3'd1;
			default:  r = 3'd0;
		endcase
		return r;
	endfunction

endpackage

/* sv/m4i_serial_unit.sv */
// Shared bit-serial unit: signed multiply-accumulate (one multiplier bit per
// cycle) and restoring division (one quotient bit per cycle), one adder.
module m4i_serial_unit #(
	parameter int AW   = 150,
	parameter int CNTW = 8,
	parameter int QW   = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  m4i_pkg::unit_cmd_t  cmd,
	input  logic [AW-1:0]       opa,
	input  logic [AW-1:0]       opb,
	input  logic [CNTW-1:0]     len,
	output logic                busy,
	output logic [AW-1:0]       acc,
	output logic [QW-1:0]       quo,
	output logic                big
);

	logic [AW-1:0]   acc_q, a_q, b_q;
	logic [QW-1:0]   q_q;
	logic            big_q, div_q, sub_q, busy_q;
	logic [CNTW-1:0] cnt_q;
	logic [AW-1:0]   x, y;
	logic            cin;
	logic [AW:0]     sum;

	// operand select for the one adder
	always_comb begin
		if (div_q) begin
			x   = {acc_q[AW-2:0], b_q[AW-1]};
			y   = ~a_q;
			cin = 1'b1;
		end else begin
			x = acc_q;
			if (b_q[0]) begin
				y   = sub_q ? ~a_q : a_q;
				cin = sub_q;
			end else begin
				y   = '0;
				cin = 1'b0;
			end
		end
		sum = {1'b0, x} + {1'b0, y} + {{AW{1'b0}}, cin};
	end

	// iteration count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			cnt_q  <= len;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNTW'(1)) busy_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			a_q   <= opa;
			b_q   <= opb;
			div_q <= cmd.div;
			sub_q <= cmd.sub;
			q_q   <= '0;
			big_q <= 1'b0;
			if (cmd.clr || cmd.div) acc_q <= '0;
		end else if (busy_q) begin
			if (div_q) begin
				acc_q <= sum[AW] ? sum[AW-1:0] : x;
				b_q   <= b_q << 1;
				q_q   <= {q_q[QW-2:0], sum[AW]};
				big_q <= big_q | q_q[QW-1];
			end else begin
				acc_q <= sum[AW-1:0];
				a_q   <= a_q << 1;
				b_q   <= b_q >> 1;
			end
		end
	end

	assign busy = busy_q;
	assign acc  = acc_q;
	assign quo  = q_q;
	assign big  = big_q;

endmodule

/* sv/matrix4_inverse.sv */
// 4x4 matrix inverse, signed fixed point (FRAC_BITS fraction bits).
// Input channel (in_valid/in_ready, element): sixteen elements, column-major,
// one request per cycle while loading; low ELEM_WIDTH bits are used.
// Output channel (out_valid/out_ready, inverse_element, last, singular):
// sixteen results in the same order; last marks the sixteenth, singular is
// set on all sixteen when the determinant is zero (results are then zero).
// After the sixteenth element in_ready drops while one bit-serial unit
// works: 12 minors (2 MACs each), the determinant (6 MACs), then per
// result 3 MACs and a division; a singular matrix skips the cofactor
// MACs and divisions and emits zero results.
// A result sits in the output register until taken; a stalled receiver
// holds the sequencer, and loading of the next matrix starts once the last
// result is in that register. Reset empties the output, clears the load
// count and returns to loading; stored elements are not cleared.
module matrix4_inverse #(
	parameter int FRAC_BITS  = m4i_pkg::FRAC_BITS_DEF,
	parameter int ELEM_WIDTH = m4i_pkg::ELEM_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [m4i_pkg::PORT_W-1:0]   element,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [m4i_pkg::PORT_W-1:0]   inverse_element,
	output logic                                last,
	output logic                                singular
);

	localparam int W    = ELEM_WIDTH;
	localparam int MW   = 2 * W + 1;
	localparam int DW   = 4 * W + 5;
	localparam int CW   = 3 * W + 3;
	localparam int NW   = CW + 2 * FRAC_BITS;
	localparam int AW   = ((DW > NW) ? DW : NW) + 1;
	localparam int CNTW = $clog2(AW + 1);

	m4i_pkg::state_t state_q, state_d;
	m4i_pkg::phase_t phase_q;

	logic [W-1:0]          store [16];
	logic [W-1:0]          rd_q, ea_q;
	logic [3:0]            raddr, addr1, addr2;
	logic [3:0]            ld_cnt_q, midx_q, k_q;
	logic [2:0]            term_q;
	logic signed [MW-1:0]  up_q [6];
	logic signed [MW-1:0]  lo_q [6];
	logic signed [DW-1:0]  det_q;
	logic                  sing_q, neg_q;
	logic                  ov_q, olast_q, osing_q;
	logic signed [m4i_pkg::PORT_W-1:0] oe_q;

	m4i_pkg::unit_cmd_t    u_cmd;
	logic [AW-1:0]         u_opa, u_opb, u_acc;
	logic [CNTW-1:0]       u_len;
	logic                  u_busy, u_big;
	logic [W-1:0]          u_quo;

	logic                  in_fire, mac_done, div_done, emit_fire, out_free;
	logic                  term_last, det_zero;
	logic [2:0]            mp;
	logic [1:0]            c0, c1, ecol, cc, rr;
	logic [W-1:0]          ea_mag, eb_mag;
	logic signed [MW-1:0]  ut, lt, ms;
	logic [MW-1:0]         um, lm, mm;
	logic signed [CW-1:0]  cof;
	logic [CW-1:0]         cmag;
	logic [DW-1:0]         den_mag;
	logic signed [W-1:0]   res;

	m4i_serial_unit #(
		.AW   (AW),
		.CNTW (CNTW),
		.QW   (W)
	) u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (u_cmd),
		.opa    (u_opa),
		.opb    (u_opb),
		.len    (u_len),
		.busy   (u_busy),
		.acc    (u_acc),
		.quo    (u_quo),
		.big    (u_big)
	);

	// element addressing
	always_comb begin
		mp   = (midx_q < 4'd6) ? midx_q[2:0] : 3'(midx_q - 4'd6);
		c0   = (midx_q < 4'd6) ? 2'd0 : 2'd2;
		c1   = c0 | 2'd1;
		cc   = k_q[3:2];
		rr   = k_q[1:0];
		ecol = rr ^ 2'd1;
		if (phase_q == m4i_pkg::PH_COF) begin
			addr1 = {ecol, m4i_pkg::cof_row(cc, term_q)};
			addr2 = addr1;
		end else if (term_q[0]) begin
			addr1 = {c1, m4i_pkg::pair_a(mp)};
			addr2 = {c0, m4i_pkg::pair_b(mp)};
		end else begin
			addr1 = {c0, m4i_pkg::pair_a(mp)};
			addr2 = {c1, m4i_pkg::pair_b(mp)};
		end
		raddr = (state_q == m4i_pkg::ST_FETCH1) ? addr1 : addr2;
	end

	// element store, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (in_fire) store[ld_cnt_q] <= element[W-1:0];
		rd_q <= store[raddr];
		if (state_q == m4i_pkg::ST_FETCH2) ea_q <= rd_q;
	end

	// operand magnitudes and signs
	always_comb begin
		ea_mag  = ea_q[W-1] ? (~ea_q + 1'b1) : ea_q;
		eb_mag  = rd_q[W-1] ? (~rd_q + 1'b1) : rd_q;
		ut      = up_q[term_q];
		lt      = lo_q[3'd5 - term_q];
		ms      = rr[1] ? up_q[m4i_pkg::cof_minor(cc, term_q)]
		                : lo_q[m4i_pkg::cof_minor(cc, term_q)];
		um      = ut[MW-1] ? MW'(-ut) : MW'(ut);
		lm      = lt[MW-1] ? MW'(-lt) : MW'(lt);
		mm      = ms[MW-1] ? MW'(-ms) : MW'(ms);
		cof     = u_acc[CW-1:0];
		cmag    = cof[CW-1] ? CW'(-cof) : CW'(cof);
		den_mag = det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
		det_zero = (u_acc[DW-1:0] == '0);
	end

	always_comb begin
		unique case (phase_q)
			m4i_pkg::PH_MINOR: term_last = (term_q == 3'd1);
			m4i_pkg::PH_DET:   term_last = (term_q == 3'd5);
			default:           term_last = (term_q == 3'd2);
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			m4i_pkg::ST_LOAD:
				if (in_valid && ld_cnt_q == 4'd15) state_d = m4i_pkg::ST_FETCH1;
			m4i_pkg::ST_FETCH1: state_d = m4i_pkg::ST_FETCH2;
			m4i_pkg::ST_FETCH2: state_d = m4i_pkg::ST_MAC_GO;
			m4i_pkg::ST_MAC_GO: state_d = m4i_pkg::ST_MAC_WAIT;
			m4i_pkg::ST_MAC_WAIT: begin
				if (!u_busy) begin
					if (!term_last) begin
						state_d = (phase_q == m4i_pkg::PH_DET) ? m4i_pkg::ST_MAC_GO
						                                       : m4i_pkg::ST_FETCH1;
					end else begin
						unique case (phase_q)
							m4i_pkg::PH_MINOR:
								state_d = (midx_q == 4'd11) ? m4i_pkg::ST_MAC_GO
								                            : m4i_pkg::ST_FETCH1;
							m4i_pkg::PH_DET:
								state_d = det_zero ? m4i_pkg::ST_EMIT : m4i_pkg::ST_FETCH1;
							default: state_d = m4i_pkg::ST_DIV_GO;
						endcase
					end
				end
			end
			m4i_pkg::ST_DIV_GO: state_d = m4i_pkg::ST_DIV_WAIT;
			m4i_pkg::ST_DIV_WAIT:
				if (!u_busy) state_d = m4i_pkg::ST_EMIT;
			m4i_pkg::ST_EMIT: begin
				if (out_free) begin
					if (k_q == 4'd15) state_d = m4i_pkg::ST_LOAD;
					else if (sing_q)  state_d = m4i_pkg::ST_EMIT;
					else              state_d = m4i_pkg::ST_FETCH1;
				end
			end
			default: state_d = m4i_pkg::ST_LOAD;
		endcase
	end

	// state outputs and unit command
	always_comb begin
		out_free  = !ov_q || out_ready;
		in_ready  = (state_q == m4i_pkg::ST_LOAD);
		in_fire   = in_ready && in_valid;
		mac_done  = (state_q == m4i_pkg::ST_MAC_WAIT) && !u_busy;
		div_done  = (state_q == m4i_pkg::ST_DIV_WAIT) && !u_busy;
		emit_fire = (state_q == m4i_pkg::ST_EMIT) && out_free;
		u_cmd     = '0;
		u_opa     = '0;
		u_opb     = '0;
		u_len     = CNTW'(W);
		if (state_q == m4i_pkg::ST_MAC_GO) begin
			u_cmd.start = 1'b1;
			u_cmd.clr   = (term_q == 3'd0);
			unique case (phase_q)
				m4i_pkg::PH_MINOR: begin
					u_opa     = AW'(ea_mag);
					u_opb     = AW'(eb_mag);
					u_cmd.sub = ea_q[W-1] ^ rd_q[W-1] ^ term_q[0];
				end
				m4i_pkg::PH_DET: begin
					u_opa     = AW'(um);
					u_opb     = AW'(lm);
					u_len     = CNTW'(MW);
					u_cmd.sub = ut[MW-1] ^ lt[MW-1] ^ (term_q == 3'd1 || term_q == 3'd4);
				end
				default: begin
					u_opa     = AW'(mm);
					u_opb     = AW'(eb_mag);
					u_cmd.sub = ms[MW-1] ^ rd_q[W-1] ^ (term_q == 3'd1) ^ k_q[2] ^ k_q[0];
				end
			endcase
		end else if (state_q == m4i_pkg::ST_DIV_GO) begin
			u_cmd.start = 1'b1;
			u_cmd.div   = 1'b1;
			u_opa       = AW'(den_mag);
			u_opb       = AW'(cmag) << (AW - CW);
			u_len       = CNTW'(NW);
		end
	end

	// saturated quotient
	always_comb begin
		if (sing_q) begin
			res = '0;
		end else if (u_big || u_quo[W-1]) begin
			res = neg_q ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		end else begin
			res = neg_q ? W'(-u_quo) : W'(u_quo);
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= m4i_pkg::ST_LOAD;
			phase_q  <= m4i_pkg::PH_MINOR;
			ld_cnt_q <= '0;
			midx_q   <= '0;
			term_q   <= '0;
			k_q      <= '0;
			sing_q   <= 1'b0;
			ov_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_fire) begin
				ld_cnt_q <= ld_cnt_q + 1'b1;
				if (ld_cnt_q == 4'd15) begin
					phase_q <= m4i_pkg::PH_MINOR;
					midx_q  <= '0;
					term_q  <= '0;
				end
			end
			if (mac_done) begin
				term_q <= term_last ? 3'd0 : term_q + 1'b1;
				if (term_last) begin
					unique case (phase_q)
						m4i_pkg::PH_MINOR: begin
							if (midx_q == 4'd11) phase_q <= m4i_pkg::PH_DET;
							midx_q <= midx_q + 1'b1;
						end
						m4i_pkg::PH_DET: begin
							phase_q <= m4i_pkg::PH_COF;
							k_q     <= '0;
							sing_q  <= det_zero;
						end
						default: ;
					endcase
				end
			end
			if (emit_fire) k_q <= k_q + 1'b1;
			if (emit_fire)      ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (mac_done && term_last) begin
			if (phase_q == m4i_pkg::PH_MINOR) begin
				if (midx_q < 4'd6) up_q[mp] <= u_acc[MW-1:0];
				else               lo_q[mp] <= u_acc[MW-1:0];
			end
			if (phase_q == m4i_pkg::PH_DET) det_q <= u_acc[DW-1:0];
		end
		if (state_q == m4i_pkg::ST_DIV_GO) neg_q <= cof[CW-1] ^ det_q[DW-1];
		if (emit_fire) begin
			oe_q    <= m4i_pkg::PORT_W'(res);
			olast_q <= (k_q == 4'd15);
			osing_q <= sing_q;
		end
	end

	assign out_valid       = ov_q;
	assign inverse_element = oe_q;
	assign last            = olast_q;
	assign singular        = osing_q;

	`include "matrix4_inverse_assert.svh"

	`M4I_NEVER(a_load_unit_idle, clk, arst_n, in_ready && u_busy, "unit busy while loading")
	`M4I_ASSERT(a_count_parked, clk, arst_n, (state_q != m4i_pkg::ST_LOAD) |-> (ld_cnt_q == 4'd0), "load count not wrapped")
	`M4I_ASSERT(a_sing_zero, clk, arst_n, (out_valid && singular) |-> (inverse_element == '0), "singular result not zero")
	`M4I_NEVER(a_div_done_sing, clk, arst_n, div_done && sing_q, "division on singular matrix")

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;

	// result of one inverse element as the block should produce it
	typedef struct {
		logic signed [31:0] value;
		logic               last;
		logic               singular;
	} inv_result_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic signed [31:0] element;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] inverse_element;
	logic               last;
	logic               singular;

	matrix4_inverse DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.element(element),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.inverse_element(inverse_element),
		.last(last),
		.singular(singular)
	);

	localparam int IDLE_LIMIT = 20000;
	localparam logic signed [31:0] ONE = 32'sh0001_0000;

	logic signed [31:0] pending_elems[$];
	inv_result_t        expected_inv[$];
	logic        [31:0] mat_copy[16];
	int                 load_idx;
	int                 err_count;
	int                 results_seen;
	int                 idle_cycles;
	bit                 in_fire;
	bit                 stim_done;
	int                 burst_left;
	int                 gap_left;
	int                 stall_left;
	bit                 long_hold_done;
	bit                 calm;

	int erow[4][3] = '{'{1, 2, 3}, '{0, 2, 3}, '{0, 1, 3}, '{0, 1, 2}};
	int midx[4][3] = '{'{5, 4, 3}, '{5, 2, 1}, '{4, 2, 0}, '{3, 1, 0}};
	int pa[6] = '{0, 0, 0, 1, 1, 2};
	int pb[6] = '{1, 2, 3, 2, 3, 3};

	// clock, 2 ns period
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic logic signed [255:0] mat_elem(int col, int row);
		logic signed [31:0] v;
		v = mat_copy[col * 4 + row];
		return v;
	endfunction

	// exact cofactor inverse of the stored matrix, sixteen results queued
	task automatic predict_inverse();
		logic signed [255:0] up[6];
		logic signed [255:0] lo[6];
		logic signed [255:0] det;
		logic signed [255:0] cof;
		logic signed [255:0] quot;
		inv_result_t         res;
		int                  c;
		int                  r;
		int                  ec;
		for (int i = 0; i < 6; i++) begin
			up[i] = mat_elem(0, pa[i]) * mat_elem(1, pb[i])
				- mat_elem(1, pa[i]) * mat_elem(0, pb[i]);
			lo[i] = mat_elem(2, pa[i]) * mat_elem(3, pb[i])
				- mat_elem(3, pa[i]) * mat_elem(2, pb[i]);
		end
		det = up[0] * lo[5] - up[1] * lo[4] + up[2] * lo[3]
			+ up[3] * lo[2] - up[4] * lo[1] + up[5] * lo[0];
		for (int k = 0; k < 16; k++) begin
			c = k >> 2;
			r = k & 3;
			ec = r ^ 1;
			res.value = 32'sd0;
			res.last = (k == 15);
			res.singular = (det == 0);
			if (det != 0) begin
				if (r < 2)
					cof = mat_elem(ec, erow[c][0]) * lo[midx[c][0]]
						- mat_elem(ec, erow[c][1]) * lo[midx[c][1]]
						+ mat_elem(ec, erow[c][2]) * lo[midx[c][2]];
				else
					cof = mat_elem(ec, erow[c][0]) * up[midx[c][0]]
						- mat_elem(ec, erow[c][1]) * up[midx[c][1]]
						+ mat_elem(ec, erow[c][2]) * up[midx[c][2]];
				if (((c + r) & 1) != 0)
					cof = -cof;
				quot = (cof <<< 32) / det;
				// saturate to 32 signed bits
				if (quot > 256'sh7fff_ffff)
					res.value = 32'sh7fff_ffff;
				else if (quot < -256'sh8000_0000)
					res.value = 32'sh8000_0000;
				else
					res.value = quot[31:0];
			end
			expected_inv.push_back(res);
		end
	endtask

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH result %0d %s: got %h want %h", results_seen, what, got, want);
		err_count++;
	endtask

	task automatic push_matrix(logic signed [31:0] m[16]);
		for (int i = 0; i < 16; i++)
			pending_elems.push_back(m[i]);
	endtask

	function automatic logic signed [31:0] rand_small();
		// roughly -4.0 .. 4.0 in Q16.16
		return $signed($urandom_range(0, 32'h7_ffff)) - 32'sh4_0000;
	endfunction

	// stimulus
	initial begin
		logic signed [31:0] m[16];
		int kind;
		int src;
		int dst;

		// identity
		for (int i = 0; i < 16; i++)
			m[i] = (i % 5 == 0) ? ONE : 32'sd0;
		push_matrix(m);
		// all zero: singular
		for (int i = 0; i < 16; i++)
			m[i] = 32'sd0;
		push_matrix(m);
		// extreme diagonal: both saturations and the field extremes
		for (int i = 0; i < 16; i++)
			m[i] = 32'sd0;
		m[0] = 32'sd1;
		m[5] = -32'sd1;
		m[10] = 32'sh7fff_ffff;
		m[15] = 32'sh8000_0000;
		push_matrix(m);

		// random matrices, mostly well conditioned
		for (int n = 0; n < 17; n++) begin
			kind = $urandom_range(0, 9);
			for (int i = 0; i < 16; i++) begin
				if (kind < 2)
					m[i] = $urandom;
				else
					m[i] = rand_small();
			end
			if (kind >= 2 && kind < 7)
				for (int i = 0; i < 4; i++)
					m[i * 5] = m[i * 5] + ((i & 1) ? -32'sh8_0000 : 32'sh8_0000);
			if (kind == 7) begin
				// duplicate column: singular
				src = $urandom_range(0, 3);
				dst = (src + $urandom_range(1, 3)) % 4;
				for (int i = 0; i < 4; i++)
					m[dst * 4 + i] = m[src * 4 + i];
			end
			if (kind == 8)
				for (int i = 0; i < 16; i++)
					m[i] = (i % 5 == 0) ? $signed($urandom_range(1, 8)) : 32'sd0;
			push_matrix(m);
		end
	end

	// reset and end of run
	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (stim_done && expected_inv.size() == 0);
		repeat (200) @(posedge clk);
		if (err_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// request driver: bursts with random gaps
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			element <= 32'sd0;
			burst_left <= 0;
			gap_left <= 0;
			stim_done <= 1'b0;
		end else if (!in_valid || in_fire) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_elems.size() != 0) begin
				in_valid <= 1'b1;
				element <= pending_elems.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 20);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
				stim_done <= 1'b1;
			end
		end
	end

	// receiver stalls, one long hold-off once results are flowing
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
			long_hold_done <= 1'b0;
			calm <= 1'b0;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!long_hold_done && results_seen >= 40) begin
			out_ready <= 1'b0;
			stall_left <= 3000;
			long_hold_done <= 1'b1;
		end else begin
			if ($urandom_range(0, 99) == 0)
				calm <= ~calm;
			if (calm)
				out_ready <= 1'b1;
			else if ($urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				stall_left <= $urandom_range(0, 5);
			end else
				out_ready <= $urandom_range(0, 2) != 0;
		end
	end

	// monitor: accept requests into the predictor, check results
	always @(posedge clk) begin
		inv_result_t want;
		in_fire = 1'b0;
		if (arst_n) begin
			in_fire = in_valid && in_ready;
			if (in_fire) begin
				mat_copy[load_idx] = element;
				if (load_idx == 15) begin
					load_idx = 0;
					predict_inverse();
				end else
					load_idx++;
			end
			if (out_valid && out_ready) begin
				if (expected_inv.size() == 0) begin
					$display("UNEXPECTED result %0d: %h", results_seen, inverse_element);
					err_count++;
				end else begin
					want = expected_inv.pop_front();
					if (inverse_element !== want.value)
						report("inverse_element", inverse_element, want.value);
					if (last !== want.last)
						report("last", last, want.last);
					if (singular !== want.singular)
						report("singular", singular, want.singular);
				end
				results_seen++;
			end
			// watchdog on stalled progress
			if (in_fire || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		load_idx = 0;
		err_count = 0;
		results_seen = 0;
		idle_cycles = 0;
	end

endmodule
